// ===== hdl/bgr_pkg.sv =====
package bgr_pkg;

  typedef enum logic [1:0] {
    FN_MAP    = 2'd0,
    FN_FONT   = 2'd1,
    FN_CURSOR = 2'd2,
    FN_DRAW   = 2'd3
  } func_t;

  localparam logic [1:0] CFG_GLYPH_W = 2'd0;
  localparam logic [1:0] CFG_GLYPH_H = 2'd1;
  localparam logic [1:0] CFG_FORE    = 2'd2;

  localparam int MAX_GLYPH_W = 8;
  localparam int MAX_GLYPH_H = 8;
  localparam int MAP_ENTRIES = 256;

  localparam logic [3:0] GLYPH_W_RESET = 4'd8;
  localparam logic [3:0] GLYPH_H_RESET = 4'd8;

endpackage

// ===== hdl/bgr_mod_add.sv =====
module bgr_mod_add #(
  parameter int MODULUS = 2048
) (
  input  logic [$clog2(MODULUS)-1:0] a,
  input  logic [$clog2(MODULUS)-1:0] b,
  output logic [$clog2(MODULUS)-1:0] sum
);

  localparam int AW = $clog2(MODULUS);
  localparam logic [AW:0] MOD_W = (AW + 1)'(MODULUS);

  logic [AW:0] raw;

  always_comb begin
    raw = {1'b0, a} + {1'b0, b};
    if (raw >= MOD_W) begin
      raw = raw - MOD_W;
    end
    sum = raw[AW-1:0];
  end

endmodule

// ===== hdl/bitmap_glyph_rasterizer_top.sv =====
// channel  direction  handshake              payload
// cmd      in         cmd_valid / cmd_stall  func, index, value, pos_x, pos_y
// pix      out        pix_valid / pix_stall  pixel_x, pixel_y, red, green, blue, last
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Loads, cursor sets and code-zero draws complete without leaving S_IDLE. Any other draw
// holds cmd_stall while a 16-step modular multiply through the shared adder finds the
// glyph base, then one glyph bit is walked per cycle unless the pix stall holds the walk.
// Reset clears the cursor and the config registers; map and font memories are not cleared.
// A stalled pix beat holds the bit walk once a second set pixel is waiting.
module bitmap_glyph_rasterizer_top #(
  parameter int FONT_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  bgr_pkg::func_t      func,
  input  logic [10:0]         index,
  input  logic [7:0]          value,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  output logic                pix_valid,
  input  logic                pix_stall,
  output logic signed [15:0]  pixel_x,
  output logic signed [15:0]  pixel_y,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  import bgr_pkg::*;

  localparam int AW = $clog2(FONT_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_MUL,
    S_FETCH,
    S_LOAD,
    S_BITS,
    S_FLUSH
  } state_t;

  state_t state;

  logic [3:0]  glyph_width;
  logic [3:0]  glyph_height;
  logic [31:0] fore_color;
  logic [15:0] cursor_x;
  logic [15:0] cursor_y;

  logic [7:0]  char_map [MAP_ENTRIES];
  logic [7:0]  font_store [FONT_BYTES];
  logic [7:0]  map_q;
  logic [7:0]  font_q;

  logic [3:0]  w_r;
  logic [3:0]  bytes_n;
  logic [3:0]  bytes_left;
  logic [AW-1:0] addr;
  logic [3:0]  mstep;
  logic [2:0]  bit_cnt;
  logic [7:0]  sh;
  logic [2:0]  col;
  logic [2:0]  row;
  logic        pend_valid;
  logic [15:0] pend_x;
  logic [15:0] pend_y;

  logic [3:0]  w_sat;
  logic [3:0]  h_sat;
  logic [7:0]  area;
  logic [AW-1:0] ua;
  logic [AW-1:0] ub;
  logic [AW-1:0] usum;
  logic        cmd_acc;
  logic        pix_free;
  logic        step;
  logic        emit;
  logic        font_re;
  logic        font_we;
  logic        map_we;
  logic        map_re;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign pix_free  = !pix_valid || !pix_stall;
  assign step      = (state == S_BITS) && (!sh[0] || !pend_valid || pix_free);
  assign emit      = (step && sh[0] && pend_valid) ||
                     ((state == S_FLUSH) && pend_valid && pix_free);

  assign w_sat = (glyph_width > 4'(MAX_GLYPH_W)) ? 4'(MAX_GLYPH_W) : glyph_width;
  assign h_sat = (glyph_height > 4'(MAX_GLYPH_H)) ? 4'(MAX_GLYPH_H) : glyph_height;
  assign area  = 8'(w_sat) * 8'(h_sat);

  assign map_we  = cmd_acc && (func == FN_MAP);
  assign map_re  = cmd_acc && (func == FN_DRAW) && (index[7:0] != 8'd0);
  assign font_we = cmd_acc && (func == FN_FONT) && (32'(index) < 32'(FONT_BYTES));
  assign font_re = (state == S_FETCH) || (step && (bit_cnt == 3'd0) && (bytes_left != 4'd0));

  always_comb begin
    ua = addr;
    ub = AW'(1);
    if (state == S_MUL) begin
      if (mstep[0]) begin
        ub = map_q[3'd7 - mstep[3:1]] ? AW'(bytes_n) : '0;
      end else begin
        ub = addr;
      end
    end
  end

  bgr_mod_add #(
    .MODULUS(FONT_BYTES)
  ) u_mod_add (
    .a  (ua),
    .b  (ub),
    .sum(usum)
  );

  always_comb begin
    if (fore_color[31]) begin
      red   = {fore_color[14:10], 3'b000};
      green = {fore_color[9:5], 3'b000};
      blue  = {fore_color[4:0], 3'b000};
    end else begin
      red   = {fore_color[7:5], 5'b00000};
      green = {fore_color[4:2], 5'b00000};
      blue  = {fore_color[1:0], 6'b000000};
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      char_map[index[7:0]] <= value;
    end
    if (map_re) begin
      map_q <= char_map[index[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_store[AW'(index)] <= value;
    end
    if (font_re) begin
      font_q <= font_store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pix_valid    <= 1'b0;
      pend_valid   <= 1'b0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      glyph_width  <= GLYPH_W_RESET;
      glyph_height <= GLYPH_H_RESET;
      fore_color   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GLYPH_W: glyph_width  <= cfg_data[3:0];
          CFG_GLYPH_H: glyph_height <= cfg_data[3:0];
          CFG_FORE:    fore_color   <= cfg_data;
          default:     ;
        endcase
      end

      if (emit) begin
        pix_valid <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (func)
              FN_CURSOR: begin
                cursor_x <= unsigned'(pos_x);
                cursor_y <= unsigned'(pos_y);
              end
              FN_DRAW: begin
                if (index[7:0] != 8'd0) begin
                  w_r     <= w_sat;
                  bytes_n <= area[6:3];
                  addr    <= '0;
                  mstep   <= '0;
                  state   <= S_MAP;
                end
              end
              default: ;
            endcase
          end
        end
        S_MAP: begin
          state <= S_MUL;
        end
        S_MUL: begin
          addr  <= usum;
          mstep <= mstep + 4'd1;
          if (mstep == 4'hf) begin
            if (bytes_n == 4'd0) begin
              cursor_x <= cursor_x + 16'(w_r);
              state    <= S_IDLE;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          addr       <= usum;
          bytes_left <= bytes_n - 4'd1;
          state      <= S_LOAD;
        end
        S_LOAD: begin
          sh      <= font_q;
          bit_cnt <= '0;
          col     <= '0;
          row     <= '0;
          state   <= S_BITS;
        end
        S_BITS: begin
          if (step) begin
            if (sh[0]) begin
              pend_valid <= 1'b1;
              pend_x     <= cursor_x + 16'(col);
              pend_y     <= cursor_y + 16'(row);
              if (pend_valid) begin
                pixel_x   <= signed'(pend_x);
                pixel_y   <= signed'(pend_y);
                last      <= 1'b0;
              end
            end
            if ((4'(col) + 4'd1) == w_r) begin
              col <= '0;
              row <= row + 3'd1;
            end else begin
              col <= col + 3'd1;
            end
            if ((bit_cnt == 3'd0) && (bytes_left != 4'd0)) begin
              addr <= usum;
            end
            bit_cnt <= bit_cnt + 3'd1;
            if (bit_cnt == 3'd7) begin
              if (bytes_left != 4'd0) begin
                sh         <= font_q;
                bytes_left <= bytes_left - 4'd1;
              end else begin
                state <= S_FLUSH;
              end
            end else begin
              sh <= sh >> 1;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            cursor_x <= cursor_x + 16'(w_r);
            state    <= S_IDLE;
          end else if (pix_free) begin
            pixel_x    <= signed'(pend_x);
            pixel_y    <= signed'(pend_y);
            last       <= 1'b1;
            pend_valid <= 1'b0;
            cursor_x   <= cursor_x + 16'(w_r);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
